// File: design/assert_macros.svh
// Assertion macros for the scan background subtraction block.
// Included by the top level, which provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BSD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked over the same edge.
`define BSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/bsd_pkg.sv
// Shared types, constants and a helper function of the background subtraction detector.
// Used by every module of the block except bsd_ram; depends on nothing.
`default_nettype none
package bsd_pkg;

  localparam int BRG_W        = 9;
  localparam int DIST_W       = 16;
  localparam int MAXS_W       = 8;
  localparam int DROP_W       = 10;
  localparam int RUN_W        = 8;
  localparam int STEP_W       = 7;
  localparam int SLOTS_W      = 8;
  localparam int BT_W         = 10;
  localparam int CNT_W        = 4;
  localparam int LOST_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 10;
  localparam int CALIB_SWEEPS = 3;
  localparam int MAX_RESULTS  = 8;
  localparam int SHELF_W      = BT_W + DIST_W;

  // Actions carried by an input transaction.
  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_SWEEP   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_COLLECT = 2'd3
  } bsd_act_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DROP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS    = 3'd4;

  typedef struct packed {
    logic [DROP_W-1:0]  min_drop;
    logic [RUN_W-1:0]   min_run;
    logic [BRG_W-1:0]   pan_min;
    logic [STEP_W-1:0]  pan_step;
    logic [SLOTS_W-1:0] slots_in_use;
  } bsd_cfg_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    bsd_act_t           act;
    logic [BRG_W-1:0]   slot;
    logic [BRG_W-1:0]   bearing;
    logic [DIST_W-1:0]  distance;
    logic [MAXS_W-1:0]  take_max;
  } bsd_cmd_t;

  typedef struct packed {
    logic               valid;
    logic               object_valid;
    logic [BT_W-1:0]    bearing_twice;
    logic [DIST_W-1:0]  nearest;
    logic [CNT_W-1:0]   count;
    logic [LOST_W-1:0]  dropped;
    logic               last;
  } bsd_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bsd_q_stat_t;

  typedef struct packed {
    logic clearing;
  } bsd_back_stat_t;

  // Median of three readings.
  function automatic logic [DIST_W-1:0] mid3(input logic [DIST_W-1:0] x,
                                             input logic [DIST_W-1:0] y,
                                             input logic [DIST_W-1:0] z);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    if (z <= lo) begin
      mid3 = lo;
    end else if (z >= hi) begin
      mid3 = hi;
    end else begin
      mid3 = z;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/bsd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; used for calibration, baseline and shelf storage.
`default_nettype none
module bsd_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/bsd_queue.sv
// Two entry command queue between the front and the back.
// Depends on bsd_pkg for the status struct.
`default_nettype none
module bsd_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] pdata,
  input  wire logic         pop,
  output logic      [W-1:0] head,
  output bsd_pkg::bsd_q_stat_t stat
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Pointer and occupancy update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= pdata;
    end
  end

endmodule
`default_nettype wire

// File: design/bsd_front.sv
// Front end: accepts transactions, maps a reading's bearing to its angle slot
// with a bit-serial divider and rejects out-of-range readings. Uses bsd_pkg.
`default_nettype none
module bsd_front #(
  parameter int ANGLE_SLOTS = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire bsd_pkg::bsd_cmd_t     in_item,
  input  wire bsd_pkg::bsd_cfg_t     cfg,
  input  wire bsd_pkg::bsd_back_stat_t back_stat,
  input  wire bsd_pkg::bsd_q_stat_t  q_stat,
  output logic                       busy,
  output logic                       push,
  output bsd_pkg::bsd_cmd_t          push_data
);

  localparam int CW = $clog2(bsd_pkg::BRG_W + 1);

  bsd_pkg::bsd_cmd_t               it_r;
  logic                            it_v_r, it_v_nxt;
  logic [bsd_pkg::BRG_W-1:0]       dvd_r, dvd_nxt;
  logic [bsd_pkg::STEP_W-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [bsd_pkg::STEP_W-1:0]      dvs;
  logic [bsd_pkg::STEP_W:0]        rsh;
  logic                            accept;
  logic                            is_read_in;
  logic                            in_range;
  logic                            drop;

  assign busy       = it_v_r || back_stat.clearing;
  assign accept     = start && !busy;
  assign is_read_in = (in_item.act == bsd_pkg::ACT_READ);
  assign dvs        = (cfg.pan_step == '0) ? bsd_pkg::STEP_W'(1) : cfg.pan_step;
  assign rsh        = {rem_r, dvd_r[bsd_pkg::BRG_W-1]};

  // The quotient must fall below both the configured and the built slot count.
  assign in_range = ({1'b0, dvd_r} < {2'b00, cfg.slots_in_use}) &&
                    (32'(dvd_r) < ANGLE_SLOTS);
  assign drop     = it_v_r && (cnt_r == '0) && (it_r.act == bsd_pkg::ACT_READ) && !in_range;
  assign push     = it_v_r && (cnt_r == '0) && !drop && !q_stat.full;

  always_comb begin
    push_data      = it_r;
    push_data.slot = dvd_r;
  end

  // Item capture and one quotient bit per cycle.
  always_comb begin
    it_v_nxt = it_v_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (rsh >= {1'b0, dvs}) begin
        rem_nxt = bsd_pkg::STEP_W'(rsh - {1'b0, dvs});
        dvd_nxt = {dvd_r[bsd_pkg::BRG_W-2:0], 1'b1};
      end else begin
        rem_nxt = rsh[bsd_pkg::STEP_W-1:0];
        dvd_nxt = {dvd_r[bsd_pkg::BRG_W-2:0], 1'b0};
      end
    end
    if (drop || push) begin
      it_v_nxt = 1'b0;
    end
    if (accept && !(is_read_in && (in_item.bearing < cfg.pan_min))) begin
      it_v_nxt = 1'b1;
      dvd_nxt  = in_item.bearing - cfg.pan_min;
      rem_nxt  = '0;
      cnt_nxt  = is_read_in ? CW'(bsd_pkg::BRG_W) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      it_v_r <= it_v_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      it_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: design/bsd_back.sv
// Back end: calibration storage, median pass, run tracking, shelf and collect drain.
// Uses bsd_pkg and instances of bsd_ram.
`default_nettype none
module bsd_back #(
  parameter int ANGLE_SLOTS = 128,
  parameter int SHELF_DEPTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bsd_pkg::bsd_cfg_t    cfg,
  input  wire bsd_pkg::bsd_cmd_t    head,
  input  wire bsd_pkg::bsd_q_stat_t q_stat,
  output logic                      pop,
  output bsd_pkg::bsd_back_stat_t   stat,
  output bsd_pkg::bsd_res_t         res
);

  localparam int SLOT_W = $clog2(ANGLE_SLOTS);
  localparam int SHW    = (SHELF_DEPTH > 1) ? $clog2(SHELF_DEPTH) : 1;
  localparam int FILL_W = $clog2(SHELF_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ANGLE_SLOTS - 1);
  localparam int DW = bsd_pkg::DIST_W;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_BASE    = 5'b00100,
    ST_MEDIAN  = 5'b01000,
    ST_COLLECT = 5'b10000
  } bsd_st_t;

  bsd_st_t                    state_r, state_nxt;
  logic                       learning_r, learning_nxt;
  logic [1:0]                 sweep_r, sweep_nxt;
  logic [bsd_pkg::BRG_W-1:0]  run_start_r, run_start_nxt;
  logic [bsd_pkg::BRG_W-1:0]  run_end_r, run_end_nxt;
  logic [DW-1:0]              run_near_r, run_near_nxt;
  logic [bsd_pkg::RUN_W-1:0]  run_len_r, run_len_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [bsd_pkg::LOST_W-1:0] lost_r, lost_nxt;
  bsd_pkg::bsd_cmd_t          cur_r, cur_nxt;
  logic [SLOT_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W-1:0]          med_cnt_r, med_cnt_nxt;
  logic [SLOT_W-1:0]          med_addr_r, med_addr_nxt;
  logic                       med_stop_r, med_stop_nxt;
  logic                       med_v_r, med_v_nxt;
  logic [bsd_pkg::CNT_W-1:0]  col_n_r, col_n_nxt;
  logic [bsd_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic [bsd_pkg::CNT_W-1:0]  rk_r, rk_nxt;
  logic                       rv_r, rv_nxt;
  bsd_pkg::bsd_res_t          res_r, res_nxt;

  logic [2:0]                 calib_we;
  logic [SLOT_W-1:0]          calib_waddr;
  logic [DW-1:0]              calib_wdata;
  logic [DW-1:0]              calib_rdata [bsd_pkg::CALIB_SWEEPS];
  logic                       base_we;
  logic [SLOT_W-1:0]          base_raddr;
  logic [DW-1:0]              base_rdata;
  logic                       shelf_we;
  logic [bsd_pkg::SHELF_W-1:0] shelf_wdata;
  logic [bsd_pkg::SHELF_W-1:0] shelf_rdata;

  logic [bsd_pkg::RUN_W-1:0]  need;
  logic                       qual;
  logic                       room;
  logic                       do_finish;
  logic                       close;
  logic [8:0]                 n_w;

  assign stat.clearing = (state_r == ST_CLEAR);
  assign res           = res_r;
  assign pop           = (state_r == ST_IDLE) && !q_stat.empty;

  // Run qualification used when a run closes.
  assign need  = (cfg.min_run == '0) ? bsd_pkg::RUN_W'(1) : cfg.min_run;
  assign qual  = (run_len_r >= need);
  assign room  = (fill_r < FILL_W'(SHELF_DEPTH));
  assign close = (({1'b0, cur_r.distance} + 17'(cfg.min_drop)) < {1'b0, base_rdata});
  assign shelf_wdata = {bsd_pkg::BT_W'({1'b0, run_start_r} + {1'b0, run_end_r}), run_near_r};

  // Number of detections a collect returns.
  always_comb begin
    n_w = 9'(fill_r);
    if (n_w > {1'b0, head.take_max}) begin
      n_w = {1'b0, head.take_max};
    end
    if (n_w > 9'(bsd_pkg::MAX_RESULTS)) begin
      n_w = 9'(bsd_pkg::MAX_RESULTS);
    end
  end

  // Sequencer of the back end.
  always_comb begin
    state_nxt     = state_r;
    learning_nxt  = learning_r;
    sweep_nxt     = sweep_r;
    run_start_nxt = run_start_r;
    run_end_nxt   = run_end_r;
    run_near_nxt  = run_near_r;
    run_len_nxt   = run_len_r;
    fill_nxt      = fill_r;
    lost_nxt      = lost_r;
    cur_nxt       = cur_r;
    clr_cnt_nxt   = clr_cnt_r;
    med_cnt_nxt   = med_cnt_r;
    med_addr_nxt  = med_addr_r;
    med_stop_nxt  = med_stop_r;
    med_v_nxt     = med_v_r;
    col_n_nxt     = col_n_r;
    k_nxt         = k_r;
    rk_nxt        = rk_r;
    rv_nxt        = rv_r;
    res_nxt       = res_r;
    res_nxt.valid = 1'b0;
    calib_we      = 3'b000;
    calib_waddr   = SLOT_W'(head.slot);
    calib_wdata   = head.distance;
    base_we       = 1'b0;
    base_raddr    = (state_r == ST_IDLE) ? SLOT_W'(head.slot) : SLOT_W'(cur_r.slot);
    shelf_we      = 1'b0;
    do_finish     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Zero the calibration store after reset, one slot a cycle.
        calib_we    = 3'b111;
        calib_waddr = clr_cnt_r;
        calib_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          cur_nxt = head;
          case (head.act)
            bsd_pkg::ACT_READ: begin
              if (learning_r) begin
                if (sweep_r < 2'(bsd_pkg::CALIB_SWEEPS)) begin
                  calib_we[sweep_r] = 1'b1;
                end
              end else begin
                state_nxt = ST_BASE;
              end
            end
            bsd_pkg::ACT_SWEEP: begin
              do_finish = 1'b1;
              if (learning_r) begin
                sweep_nxt = sweep_r + 2'd1;
                if (sweep_r + 2'd1 == 2'(bsd_pkg::CALIB_SWEEPS)) begin
                  state_nxt    = ST_MEDIAN;
                  med_cnt_nxt  = '0;
                  med_stop_nxt = 1'b0;
                  med_v_nxt    = 1'b0;
                end
              end
            end
            bsd_pkg::ACT_RESTART: begin
              sweep_nxt    = 2'd0;
              learning_nxt = 1'b1;
              fill_nxt     = '0;
              run_len_nxt  = '0;
            end
            bsd_pkg::ACT_COLLECT: begin
              fill_nxt = '0;
              if (n_w == '0) begin
                res_nxt.valid         = 1'b1;
                res_nxt.object_valid  = 1'b0;
                res_nxt.bearing_twice = '0;
                res_nxt.nearest       = '0;
                res_nxt.count         = '0;
                res_nxt.dropped       = lost_r;
                res_nxt.last          = 1'b1;
              end else begin
                col_n_nxt = bsd_pkg::CNT_W'(n_w);
                k_nxt     = '0;
                rv_nxt    = 1'b0;
                state_nxt = ST_COLLECT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BASE: begin
        // Baseline is now read out; extend or close the run.
        state_nxt = ST_IDLE;
        if (close) begin
          if (run_len_r == '0) begin
            run_start_nxt = cur_r.bearing;
            run_near_nxt  = cur_r.distance;
          end else if (cur_r.distance < run_near_r) begin
            run_near_nxt = cur_r.distance;
          end
          run_end_nxt = cur_r.bearing;
          if (run_len_r != '1) begin
            run_len_nxt = run_len_r + bsd_pkg::RUN_W'(1);
          end
        end else begin
          do_finish = 1'b1;
        end
      end
      ST_MEDIAN: begin
        // Read three sweeps per slot, write their median in the following cycle.
        if (!med_stop_r) begin
          med_cnt_nxt  = med_cnt_r + SLOT_W'(1);
          med_addr_nxt = med_cnt_r;
          med_v_nxt    = 1'b1;
          if (med_cnt_r == LAST_SLOT) begin
            med_stop_nxt = 1'b1;
          end
        end else begin
          med_v_nxt = 1'b0;
        end
        if (med_v_r) begin
          base_we = 1'b1;
          if (med_addr_r == LAST_SLOT) begin
            learning_nxt = 1'b0;
            med_v_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_COLLECT: begin
        // Stream the shelf out oldest first.
        if (k_r < col_n_r) begin
          k_nxt  = k_r + bsd_pkg::CNT_W'(1);
          rk_nxt = k_r;
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          res_nxt.valid         = 1'b1;
          res_nxt.object_valid  = 1'b1;
          res_nxt.bearing_twice = shelf_rdata[bsd_pkg::SHELF_W-1:DW];
          res_nxt.nearest       = shelf_rdata[DW-1:0];
          res_nxt.count         = col_n_r;
          res_nxt.dropped       = lost_r;
          res_nxt.last          = (rk_r + bsd_pkg::CNT_W'(1) == col_n_r);
          if (rk_r + bsd_pkg::CNT_W'(1) == col_n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A closing run that qualifies goes to the shelf, or counts as lost when the shelf is full.
    if (do_finish) begin
      run_len_nxt = '0;
      if (qual && room) begin
        shelf_we = 1'b1;
        fill_nxt = fill_r + FILL_W'(1);
      end else if (qual) begin
        lost_nxt = lost_r + bsd_pkg::LOST_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      learning_r <= 1'b1;
      sweep_r    <= 2'd0;
      run_len_r  <= '0;
      fill_r     <= '0;
      lost_r     <= '0;
      clr_cnt_r  <= '0;
      med_stop_r <= 1'b0;
      med_v_r    <= 1'b0;
      rv_r       <= 1'b0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      learning_r <= learning_nxt;
      sweep_r    <= sweep_nxt;
      run_len_r  <= run_len_nxt;
      fill_r     <= fill_nxt;
      lost_r     <= lost_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      med_stop_r <= med_stop_nxt;
      med_v_r    <= med_v_nxt;
      rv_r       <= rv_nxt;
      res_r      <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_start_r <= run_start_nxt;
    run_end_r   <= run_end_nxt;
    run_near_r  <= run_near_nxt;
    cur_r       <= cur_nxt;
    med_cnt_r   <= med_cnt_nxt;
    med_addr_r  <= med_addr_nxt;
    col_n_r     <= col_n_nxt;
    k_r         <= k_nxt;
    rk_r        <= rk_nxt;
  end

  // One calibration RAM per sweep so a slot's three samples read together.
  for (genvar g = 0; g < bsd_pkg::CALIB_SWEEPS; g++) begin : g_calib
    bsd_ram #(.W(DW), .DEPTH(ANGLE_SLOTS)) u_calib (
      .clk   (clk),
      .we    (calib_we[g]),
      .waddr (calib_waddr),
      .wdata (calib_wdata),
      .raddr (med_cnt_r),
      .rdata (calib_rdata[g])
    );
  end

  bsd_ram #(.W(DW), .DEPTH(ANGLE_SLOTS)) u_base (
    .clk   (clk),
    .we    (base_we),
    .waddr (med_addr_r),
    .wdata (bsd_pkg::mid3(calib_rdata[0], calib_rdata[1], calib_rdata[2])),
    .raddr (base_raddr),
    .rdata (base_rdata)
  );

  bsd_ram #(.W(bsd_pkg::SHELF_W), .DEPTH(SHELF_DEPTH)) u_shelf (
    .clk   (clk),
    .we    (shelf_we),
    .waddr (SHW'(fill_r)),
    .wdata (shelf_wdata),
    .raddr (SHW'(k_r)),
    .rdata (shelf_rdata)
  );

endmodule
`default_nettype wire

// File: design/scan_background_subtract_detector.sv
// Top level of the scan background subtraction run detector.
// Depends on bsd_pkg, bsd_front, bsd_queue, bsd_back, bsd_ram and assert_macros.svh.
//
//   Channel   Handshake                 Payload
//   input     start, busy               in_action, in_bearing, in_distance, in_max_slots
//   result    out_valid (strobe)        out_object_valid .. out_last
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A reading holds the front busy while the bit-serial slot divider works out its slot,
// then while it is pushed into the queue; the next transaction is accepted after that.
// The back then pops it, reads the baseline RAM and visits ST_BASE. Other actions skip
// the divider. The sweep end that closes calibration holds the back for the median
// pass over all ANGLE_SLOTS slots; a collect holds it while its detections stream out.
// While the queue is full a pending item waits in the front with busy high. After reset
// a clearing pass zeroes the calibration RAMs, with busy high. Results are one-cycle
// strobes; the receiver cannot stall them.
`default_nettype none
`include "assert_macros.svh"
module scan_background_subtract_detector #(
  parameter int ANGLE_SLOTS = 128,
  parameter int SHELF_DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_action,
  input  wire logic [bsd_pkg::BRG_W-1:0]          in_bearing,
  input  wire logic [bsd_pkg::DIST_W-1:0]         in_distance,
  input  wire logic [bsd_pkg::MAXS_W-1:0]         in_max_slots,
  output logic                                    out_valid,
  output logic                                    out_object_valid,
  output logic [bsd_pkg::BT_W-1:0]                out_bearing_twice,
  output logic [bsd_pkg::DIST_W-1:0]              out_nearest_distance,
  output logic [bsd_pkg::CNT_W-1:0]               out_returned_count,
  output logic [bsd_pkg::LOST_W-1:0]              out_dropped_runs,
  output logic                                    out_last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bsd_pkg::bsd_cfg_t       cfg_r, cfg_nxt;
  bsd_pkg::bsd_cmd_t       in_item;
  bsd_pkg::bsd_cmd_t       push_data;
  bsd_pkg::bsd_cmd_t       head;
  bsd_pkg::bsd_q_stat_t    q_stat;
  bsd_pkg::bsd_back_stat_t back_stat;
  bsd_pkg::bsd_res_t       res;
  logic                    push;
  logic                    pop;
  logic [$bits(bsd_pkg::bsd_cmd_t)-1:0] head_bits;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsd_pkg::CFG_MIN_DROP: cfg_nxt.min_drop     = cfg_data;
        bsd_pkg::CFG_MIN_RUN:  cfg_nxt.min_run      = cfg_data[bsd_pkg::RUN_W-1:0];
        bsd_pkg::CFG_PAN_MIN:  cfg_nxt.pan_min      = cfg_data[bsd_pkg::BRG_W-1:0];
        bsd_pkg::CFG_PAN_STEP: cfg_nxt.pan_step     = cfg_data[bsd_pkg::STEP_W-1:0];
        bsd_pkg::CFG_SLOTS:    cfg_nxt.slots_in_use = cfg_data[bsd_pkg::SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_drop     <= 10'd40;
      cfg_r.min_run      <= 8'd3;
      cfg_r.pan_min      <= 9'd0;
      cfg_r.pan_step     <= 7'd2;
      cfg_r.slots_in_use <= 8'd91;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input transaction as a command.
  always_comb begin
    in_item.act      = bsd_pkg::bsd_act_t'(in_action);
    in_item.slot     = '0;
    in_item.bearing  = in_bearing;
    in_item.distance = in_distance;
    in_item.take_max = in_max_slots;
  end

  bsd_front #(.ANGLE_SLOTS(ANGLE_SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .back_stat (back_stat),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  bsd_queue #(.W($bits(bsd_pkg::bsd_cmd_t))) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pdata (push_data),
    .pop   (pop),
    .head  (head_bits),
    .stat  (q_stat)
  );

  assign head = bsd_pkg::bsd_cmd_t'(head_bits);

  bsd_back #(.ANGLE_SLOTS(ANGLE_SLOTS), .SHELF_DEPTH(SHELF_DEPTH)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .stat   (back_stat),
    .res    (res)
  );

  assign out_valid            = res.valid;
  assign out_object_valid     = res.object_valid;
  assign out_bearing_twice    = res.bearing_twice;
  assign out_nearest_distance = res.nearest;
  assign out_returned_count   = res.count;
  assign out_dropped_runs     = res.dropped;
  assign out_last             = res.last;

  // Checks on the block's own logic.
  `BSD_ASSERT(a_no_push_full, !(push && q_stat.full), "command pushed into a full queue")
  `BSD_ASSERT_IMP(a_empty_collect, out_valid && !out_object_valid, out_last && (out_returned_count == '0), "empty collect result malformed")
  `BSD_ASSERT_IMP(a_det_count, out_valid && out_object_valid, (out_returned_count != '0) && (out_returned_count <= 4'd8), "detection count out of range")
  `BSD_ASSERT_IMP(a_no_result_clear, back_stat.clearing, !out_valid && !pop, "activity during clearing pass")

endmodule
`default_nettype wire

// File: tb/sv/bsd_checker.sv
// Checker for the scan background subtraction detector: watches the three channels,
// predicts every collect result and compares it field by field. Depends on bsd_pkg.
`default_nettype none
module bsd_checker #(
  parameter int ANGLE_SLOTS = 128,
  parameter int SHELF_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [1:0]                    in_action,
  input  wire logic [bsd_pkg::BRG_W-1:0]     in_bearing,
  input  wire logic [bsd_pkg::DIST_W-1:0]    in_distance,
  input  wire logic [bsd_pkg::MAXS_W-1:0]    in_max_slots,
  input  wire logic                          out_valid,
  input  wire logic                          out_object_valid,
  input  wire logic [bsd_pkg::BT_W-1:0]      out_bearing_twice,
  input  wire logic [bsd_pkg::DIST_W-1:0]    out_nearest_distance,
  input  wire logic [bsd_pkg::CNT_W-1:0]     out_returned_count,
  input  wire logic [bsd_pkg::LOST_W-1:0]    out_dropped_runs,
  input  wire logic                          out_last,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsd_pkg::*;

  typedef struct {
    logic              obj;
    logic [BT_W-1:0]   bt;
    logic [DIST_W-1:0] nearest;
    logic [CNT_W-1:0]  count;
    logic [LOST_W-1:0] lost;
    logic              last;
  } pred_t;

  pred_t detection_q[$];

  // Predicted configuration and state of the block.
  logic [DROP_W-1:0]  drop_thr;
  logic [RUN_W-1:0]   run_thr;
  logic [BRG_W-1:0]   first_brg;
  logic [STEP_W-1:0]  brg_step;
  logic [SLOTS_W-1:0] slot_cnt;
  logic [DIST_W-1:0]  sample_mem [0:ANGLE_SLOTS*CALIB_SWEEPS-1];
  logic [DIST_W-1:0]  base_mem [0:ANGLE_SLOTS-1];
  logic               calibrating;
  logic [1:0]         sweep_no;
  logic [BRG_W-1:0]   run_first;
  logic [BRG_W-1:0]   run_final;
  logic [DIST_W-1:0]  run_close;
  logic [7:0]         run_len;
  logic [BT_W-1:0]    shelf_bt [0:SHELF_DEPTH-1];
  logic [DIST_W-1:0]  shelf_near [0:SHELF_DEPTH-1];
  int                 shelf_cnt;
  logic [LOST_W-1:0]  lost_cnt;

  task automatic report(input string msg);
    $display("checker: %0t %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // A run that closes is shelved if long enough, or counted as lost when the shelf is full.
  task automatic shelve_run();
    logic [7:0] need;
    need = (run_thr == 0) ? 8'd1 : run_thr;
    if (run_len >= need) begin
      if (shelf_cnt < SHELF_DEPTH) begin
        shelf_bt[shelf_cnt] = BT_W'({1'b0, run_first} + {1'b0, run_final});
        shelf_near[shelf_cnt] = run_close;
        shelf_cnt++;
      end else begin
        lost_cnt = lost_cnt + 1'b1;
      end
    end
    run_len = 0;
  endtask

  task automatic take_reading(input logic [BRG_W-1:0] brg, input logic [DIST_W-1:0] rng);
    int step;
    int lim;
    int slot;
    step = (brg_step == 0) ? 1 : int'(brg_step);
    lim = (int'(slot_cnt) > ANGLE_SLOTS) ? ANGLE_SLOTS : int'(slot_cnt);
    if (brg < first_brg) return;
    slot = (int'(brg) - int'(first_brg)) / step;
    if (slot >= lim) return;
    if (calibrating) begin
      if (sweep_no < CALIB_SWEEPS) sample_mem[slot*CALIB_SWEEPS + sweep_no] = rng;
    end else if (int'(rng) + int'(drop_thr) < int'(base_mem[slot])) begin
      if (run_len == 0) begin
        run_first = brg;
        run_close = rng;
      end
      run_final = brg;
      if (rng < run_close) run_close = rng;
      if (run_len < 8'd255) run_len++;
    end else begin
      shelve_run();
    end
  endtask

  // Median of three samples per slot becomes the baseline after the third sweep; every sweep end also closes the run.
  task automatic end_sweep();
    logic [DIST_W-1:0] a, b, c, lo, hi;
    if (calibrating) begin
      sweep_no = sweep_no + 1'b1;
      if (sweep_no == CALIB_SWEEPS) begin
        for (int i = 0; i < ANGLE_SLOTS; i++) begin
          a = sample_mem[i*3];
          b = sample_mem[i*3+1];
          c = sample_mem[i*3+2];
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          base_mem[i] = (c <= lo) ? lo : ((c >= hi) ? hi : c);
        end
        calibrating = 1'b0;
      end
    end
    shelve_run();
  endtask

  task automatic collect(input logic [MAXS_W-1:0] limit);
    int n;
    pred_t d;
    n = shelf_cnt;
    if (n > int'(limit)) n = int'(limit);
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    shelf_cnt = 0;
    if (n == 0) begin
      d = '{obj: 1'b0, bt: '0, nearest: '0, count: '0, lost: lost_cnt, last: 1'b1};
      detection_q.push_back(d);
    end
    for (int k = 0; k < n; k++) begin
      d = '{obj: 1'b1, bt: shelf_bt[k], nearest: shelf_near[k], count: CNT_W'(n),
            lost: lost_cnt, last: (k + 1 == n)};
      detection_q.push_back(d);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    pred_t e;
    if (!rst_n) begin
      drop_thr = 10'd40;
      run_thr = 8'd3;
      first_brg = '0;
      brg_step = 7'd2;
      slot_cnt = 8'd91;
      foreach (sample_mem[i]) sample_mem[i] = '0;
      foreach (base_mem[i]) base_mem[i] = '0;
      calibrating = 1'b1;
      sweep_no = '0;
      run_len = '0;
      shelf_cnt = 0;
      lost_cnt = '0;
      detection_q.delete();
    end else begin
      // Result transactions are checked against the oldest prediction.
      if (out_valid) begin
        if (detection_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = detection_q.pop_front();
          check_field("object_valid", out_object_valid, e.obj);
          check_field("bearing_twice", out_bearing_twice, e.bt);
          check_field("nearest_distance", out_nearest_distance, e.nearest);
          check_field("returned_count", out_returned_count, e.count);
          check_field("dropped_runs", out_dropped_runs, e.lost);
          check_field("last", out_last, e.last);
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_DROP: drop_thr = cfg_data[DROP_W-1:0];
          CFG_MIN_RUN:  run_thr = cfg_data[RUN_W-1:0];
          CFG_PAN_MIN:  first_brg = cfg_data[BRG_W-1:0];
          CFG_PAN_STEP: brg_step = cfg_data[STEP_W-1:0];
          CFG_SLOTS:    slot_cnt = cfg_data[SLOTS_W-1:0];
          default: ;
        endcase
      end
      // Input transactions update the predicted state.
      if (start && !busy) begin
        case (bsd_act_t'(in_action))
          ACT_READ:  take_reading(in_bearing, in_distance);
          ACT_SWEEP: end_sweep();
          ACT_RESTART: begin
            sweep_no = '0;
            calibrating = 1'b1;
            shelf_cnt = 0;
            run_len = '0;
          end
          ACT_COLLECT: collect(in_max_slots);
          default: ;
        endcase
      end
    end
    pending = detection_q.size();
  end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the scan background
// subtraction detector. Depends on bsd_pkg, the block and bsd_checker.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsd_pkg::*;

  localparam int SLOTS_MAX = 128;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_action = '0;
  logic [BRG_W-1:0]      in_bearing = '0;
  logic [DIST_W-1:0]     in_distance = '0;
  logic [MAXS_W-1:0]     in_max_slots = '0;
  logic                  out_valid;
  logic                  out_object_valid;
  logic [BT_W-1:0]       out_bearing_twice;
  logic [DIST_W-1:0]     out_nearest_distance;
  logic [CNT_W-1:0]      out_returned_count;
  logic [LOST_W-1:0]     out_dropped_runs;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;

  // Stimulus view of the current settings.
  int first_brg = 0;
  int brg_step = 2;
  int slot_cnt = 91;
  int calib_slots = 0;
  int burst_left = 0;

  scan_background_subtract_detector u_dut (.*);

  bsd_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  // One input transaction; the sender works in bursts with random gaps between them.
  task automatic send(input bsd_act_t act, input int brg, input int rng, input int maxs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act;
    in_bearing <= BRG_W'(brg);
    in_distance <= DIST_W'(rng);
    in_max_slots <= MAXS_W'(maxs);
    // Busy is sampled as it stood at the edge, so the edge found is the accepting one.
    @(posedge clk iff !busy);
  endtask

  // Pause until every result has come and the block has settled.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SLOTS_MAX + 20) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int drop, input int runs, input int pmin, input int step,
                            input int slots);
    write_reg(CFG_MIN_DROP, drop);
    write_reg(CFG_MIN_RUN, runs);
    write_reg(CFG_PAN_MIN, pmin);
    write_reg(CFG_PAN_STEP, step);
    write_reg(CFG_SLOTS, slots);
    first_brg = pmin;
    brg_step = (step == 0) ? 1 : step;
    slot_cnt = (slots > SLOTS_MAX) ? SLOTS_MAX : slots;
  endtask

  function automatic int slot_bearing(input int k);
    int b;
    b = first_brg + k * brg_step + $urandom_range(0, brg_step - 1);
    return (b > 360) ? 360 : b;
  endfunction

  // Restart and three calibration sweeps over the first few slots, far ranges.
  task automatic calibrate(input int nslots);
    calib_slots = nslots;
    send(ACT_RESTART, $urandom_range(0, 360), $urandom, $urandom);
    for (int s = 0; s < CALIB_SWEEPS; s++) begin
      for (int k = 0; k < nslots; k++) begin
        send(ACT_READ, slot_bearing(k), $urandom_range(20000, 65535), $urandom);
      end
      send(ACT_SWEEP, $urandom_range(0, 360), $urandom, $urandom);
    end
  endtask

  // Watching traffic: mostly readings over calibrated slots, with noise mixed in.
  task automatic watch(input int n);
    int pick;
    int rng;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      rng = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 1500)
                                         : $urandom_range(60000, 65535);
      if (pick < 72) begin
        send(ACT_READ, slot_bearing($urandom_range(0, calib_slots)), rng, $urandom);
      end else if (pick < 78) begin
        send(ACT_READ, $urandom_range(0, 360), $urandom, $urandom);
      end else if (pick < 88) begin
        send(ACT_SWEEP, $urandom_range(0, 360), $urandom, $urandom);
      end else if (pick < 98) begin
        send(ACT_COLLECT, $urandom_range(0, 360), $urandom,
             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10));
      end else begin
        calibrate($urandom_range(1, 6));
      end
    end
    send(ACT_COLLECT, 0, 0, 255);
  endtask

  // Phase with random settings in a useful range.
  task automatic random_phase(input int n);
    wait_quiet();
    set_config($urandom_range(0, 500), $urandom_range(1, 4), $urandom_range(0, 100),
               $urandom_range(1, 20), $urandom_range(4, 16));
    calibrate($urandom_range(3, 5));
    watch(n);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on reset settings: field extremes, empty collects, rejects.
    calib_slots = 2;
    send(ACT_READ, 0, 65535, 0);
    send(ACT_READ, 2, 0, 255);
    send(ACT_SWEEP, 0, 0, 0);
    send(ACT_READ, 1, 65535, 0);
    send(ACT_READ, 3, 65535, 0);
    send(ACT_SWEEP, 360, 65535, 255);
    send(ACT_READ, 0, 65535, 0);
    send(ACT_READ, 2, 50000, 0);
    send(ACT_SWEEP, 0, 0, 0);
    send(ACT_COLLECT, 0, 0, 255);
    send(ACT_READ, 0, 0, 0);
    send(ACT_READ, 1, 7, 0);
    send(ACT_READ, 360, 0, 0);
    send(ACT_READ, 3, 65535, 0);
    send(ACT_READ, 2, 0, 0);
    send(ACT_READ, 2, 100, 0);
    send(ACT_READ, 3, 1, 0);
    send(ACT_SWEEP, 0, 0, 0);
    send(ACT_COLLECT, 511, 65535, 0);
    send(ACT_READ, 0, 300, 0);
    send(ACT_READ, 1, 200, 0);
    send(ACT_READ, 2, 400, 0);
    send(ACT_SWEEP, 0, 0, 0);
    send(ACT_COLLECT, 0, 0, 255);
    send(ACT_RESTART, 0, 0, 0);
    send(ACT_COLLECT, 0, 0, 1);

    // Every slot in use, no threshold on drop, single-reading runs.
    wait_quiet();
    set_config(0, 1, 0, 1, 128);
    calibrate(6);
    watch(20);

    // Top extremes: one slot at bearing 360, widest drop and a long run.
    wait_quiet();
    set_config(1023, 10, 360, 90, 1);
    calibrate(1);
    for (int i = 0; i < 12; i++) send(ACT_READ, 360, $urandom_range(0, 5000), 0);
    send(ACT_SWEEP, 0, 0, 0);
    send(ACT_COLLECT, 0, 0, 8);

    // Zero step and zero run threshold, slot count above the slot array.
    wait_quiet();
    set_config(100, 0, 10, 0, 200);
    calibrate(4);
    watch(20);

    // More runs than the shelf holds, so the lost counter moves.
    wait_quiet();
    set_config(30, 2, 20, 5, 12);
    calibrate(3);
    for (int r = 0; r < 9; r++) begin
      send(ACT_READ, slot_bearing(r % 3), $urandom_range(0, 1000), 0);
      send(ACT_READ, slot_bearing((r + 1) % 3), $urandom_range(0, 1000), 0);
      send(ACT_READ, slot_bearing(r % 3), 65535, 0);
    end
    send(ACT_COLLECT, 0, 0, 255);
    watch(10);

    repeat (3) random_phase(10);

    wait_quiet();
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
